/* rtl/core/pts_pkg.sv */
// Shared constants, types and functions of the priority thread scheduler.
`default_nettype none

package pts_pkg;

  localparam int THREADS    = 8;
  localparam int TIDX_W     = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int MASK_W     = 8;
  localparam int PRIO_W     = 16;
  localparam int STEP_W     = 16;
  localparam int CHOSEN_W   = 3;
  localparam int DEPTH_W    = 3;
  localparam int ORDER_W    = 24;
  localparam int SLOT_W     = 3;
  localparam int CP_COUNT   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef logic signed [PRIO_W-1:0] prio_t;
  typedef logic [STEP_W-1:0]        step_t;
  typedef logic [DEPTH_W-1:0]       depth_t;
  typedef logic [ORDER_W-1:0]       order_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH  = 3'd0,
    REG_CP1    = 3'd1,
    REG_CP2    = 3'd2,
    REG_CP3    = 3'd3,
    REG_ORDER  = 3'd4
  } cfg_reg_t;

  localparam depth_t DEPTH_RST = 3'd2;
  localparam step_t  CP_RST    = 16'd1;
  localparam order_t ORDER_RST = 24'd16434824;
  localparam prio_t  PRIO_MIN  = 16'sh8000;
  localparam step_t  STEP_MAX  = '1;

  function automatic prio_t reload_prio(input depth_t depth, input order_t order,
                                        input int t);
    logic [SLOT_W-1:0] slot;
    slot = SLOT_W'(order >> (SLOT_W * t));
    return $signed({{(PRIO_W-DEPTH_W){1'b0}}, depth})
         + $signed({{(PRIO_W-SLOT_W){1'b0}}, slot});
  endfunction

endpackage

`default_nettype wire

/* rtl/core/pct_priority_thread_scheduler.sv */
// Top level of the priority thread scheduler: selection, table update and result buffer.
//
//   Channel  Signals                                  Direction  Beat
//   item     item_valid/item_stall, start_run, masks  in         one decision request
//   result   result_valid/result_stall, result fields out        one decision
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data in         one register write
//
// One item is accepted per cycle while item_stall is low; its result is registered in the
// output register or skid entry. The argmax over the priority registers is combinational, as is
// the table update. A two-entry output buffer takes one more transfer while the result side
// stalls; then the input stalls until the skid entry moves into the output register.
// Synchronous reset loads the priorities from the reset values of depth and start order.
`default_nettype none

module pct_priority_thread_scheduler (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            item_valid,
  output logic                           item_stall,
  input  wire                            start_run,
  input  wire  [pts_pkg::MASK_W-1:0]     enabled_mask,
  input  wire  [pts_pkg::MASK_W-1:0]     yield_mask,
  output logic                           result_valid,
  input  wire                            result_stall,
  output logic [pts_pkg::CHOSEN_W-1:0]   chosen_thread,
  output logic                           no_thread_enabled,
  output logic                           lowered_for_yield,
  output logic                           hit_change_point,
  output logic [pts_pkg::STEP_W-1:0]     step_count,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [pts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [pts_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pts_pkg::*;

  typedef struct packed {
    logic [CHOSEN_W-1:0] chosen;
    logic                none;
    logic                lowered;
    logic                hit;
    step_t               steps;
  } result_t;

  depth_t depth;
  step_t  change_point [CP_COUNT];
  order_t start_order;

  prio_t  priority_table [THREADS];
  prio_t  next_yield_priority;
  step_t  steps_taken;

  prio_t  priority_table_next [THREADS];
  prio_t  next_yield_priority_next;
  step_t  steps_taken_next;

  result_t out_reg;
  result_t skid;
  logic    skid_valid;
  result_t res;

  logic               accept;
  logic               out_fire;
  logic [THREADS-1:0] en;
  logic [THREADS-1:0] yl;
  prio_t              base [THREADS];
  prio_t              yp_base;
  step_t              steps_base;
  logic [TIDX_W-1:0]  best;
  logic               found;
  logic               multi;
  logic               lowered;
  logic               hit;
  prio_t              best_prio;

  assign cfg_ready  = 1'b1;
  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign out_fire   = result_valid && !result_stall;

  assign en = THREADS'(enabled_mask);
  assign yl = THREADS'(yield_mask);

  always_comb begin
    for (int t = 0; t < THREADS; t++) begin
      base[t] = start_run ? reload_prio(depth, start_order, t) : priority_table[t];
    end
    yp_base    = start_run ? '0 : next_yield_priority;
    steps_base = start_run ? '0 : steps_taken;

    found = 1'b0;
    best  = '0;
    for (int t = 0; t < THREADS; t++) begin
      if (en[t] && (!found || base[t] > base[best])) begin
        best  = TIDX_W'(t);
        found = 1'b1;
      end
    end
    multi = (en & (en - 1'b1)) != '0;

    lowered                  = found && yl[best];
    best_prio                = base[best];
    next_yield_priority_next = yp_base;
    if (lowered) begin
      best_prio = yp_base;
      if (yp_base != PRIO_MIN) begin
        next_yield_priority_next = yp_base - 1'b1;
      end
    end

    steps_taken_next = steps_base;
    if (found && (multi || steps_base != '0) && steps_base != STEP_MAX) begin
      steps_taken_next = steps_base + 1'b1;
    end

    hit = 1'b0;
    for (int i = 0; i < CP_COUNT; i++) begin
      if (found && depth > DEPTH_W'(i + 1) && steps_taken_next == change_point[i]) begin
        best_prio = $signed({{(PRIO_W-DEPTH_W){1'b0}}, depth}) - prio_t'(i + 1);
        hit       = 1'b1;
      end
    end

    for (int t = 0; t < THREADS; t++) begin
      priority_table_next[t] = (found && best == TIDX_W'(t)) ? best_prio : base[t];
    end

    res.chosen  = CHOSEN_W'(best);
    res.none    = !found;
    res.lowered = lowered;
    res.hit     = hit;
    res.steps   = steps_taken_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth       <= DEPTH_RST;
      start_order <= ORDER_RST;
      for (int i = 0; i < CP_COUNT; i++) begin
        change_point[i] <= CP_RST;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEPTH: depth           <= cfg_data[DEPTH_W-1:0];
        REG_CP1:   change_point[0] <= cfg_data[STEP_W-1:0];
        REG_CP2:   change_point[1] <= cfg_data[STEP_W-1:0];
        REG_CP3:   change_point[2] <= cfg_data[STEP_W-1:0];
        REG_ORDER: start_order     <= cfg_data[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < THREADS; t++) begin
        priority_table[t] <= reload_prio(DEPTH_RST, ORDER_RST, t);
      end
      next_yield_priority <= '0;
      steps_taken         <= '0;
    end else if (accept) begin
      priority_table      <= priority_table_next;
      next_yield_priority <= next_yield_priority_next;
      steps_taken         <= steps_taken_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_reg    <= skid;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!result_valid || out_fire) begin
        out_reg      <= res;
        result_valid <= 1'b1;
      end else begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      result_valid <= 1'b0;
    end
  end

  assign chosen_thread     = out_reg.chosen;
  assign no_thread_enabled = out_reg.none;
  assign lowered_for_yield = out_reg.lowered;
  assign hit_change_point  = out_reg.hit;
  assign step_count        = out_reg.steps;

endmodule

`default_nettype wire

/* rtl/core/pts_checker.sv */
// Port-level checks of the priority thread scheduler and their binding to the top level.
`default_nettype none

module pts_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            item_valid,
  input wire                            item_stall,
  input wire                            result_valid,
  input wire                            result_stall,
  input wire  [pts_pkg::CHOSEN_W-1:0]   chosen_thread,
  input wire                            no_thread_enabled,
  input wire                            lowered_for_yield,
  input wire                            hit_change_point,
  input wire  [pts_pkg::STEP_W-1:0]     step_count
);
  import pts_pkg::*;

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(step_count)
      && $stable(chosen_thread) && $stable(no_thread_enabled))
    else $error("Stalled result changed or dropped.");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && no_thread_enabled |->
      !lowered_for_yield && !hit_change_point && chosen_thread == '0)
    else $error("Result with no enabled thread carries a grant.");

  a_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("Buffer not empty after reset.");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && !result_valid |=> result_valid)
    else $error("Transfer into an empty output did not produce a result.");

endmodule

bind pct_priority_thread_scheduler pts_checker u_pts_checker (.*);

`default_nettype wire
